@@ hw/rtl/idd_pkg.sv @@
// Shared types and constants for the isotropic diffusion denoiser.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package idd_pkg;

    // item opcodes (code 3 is unused and dropped)
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROWS    = 2'd0,
        CFG_COLUMNS = 2'd1,
        CFG_GAIN    = 2'd2,
        CFG_PASSES  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_ISSUE,
        ST_READ_DATA,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_PASS_INIT,
        ST_PIXEL,
        ST_DONE
    } state_t;

    // phases of the per-pixel stencil sequence
    typedef enum logic [2:0] {
        PH_CENTER = 3'd0,
        PH_UP     = 3'd1,
        PH_LEFT   = 3'd2,
        PH_RIGHT  = 3'd3,
        PH_DOWN   = 3'd4,
        PH_SUM    = 3'd5,
        PH_MUL    = 3'd6,
        PH_WRITE  = 3'd7
    } phase_t;

    localparam int PIXEL_INT_BITS = 8;
    localparam int GAIN_WIDTH     = 15;
    localparam int GAIN_SHIFT     = 16;
    localparam int SIZE_WIDTH     = 9;
    localparam int PASS_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int MIN_SIZE       = 3;

    localparam logic [8:0]  ROWS_RESET    = 9'd256;
    localparam logic [8:0]  COLUMNS_RESET = 9'd256;
    localparam logic [14:0] GAIN_RESET    = 15'd1638;
    localparam logic [15:0] PASSES_RESET  = 16'd1;

endpackage

@@ hw/rtl/idd_frame_ram.sv @@
// Single frame buffer: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module idd_frame_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/isotropic_diffusion_denoise_core.sv @@
// Top level of the isotropic diffusion denoiser: control sequencer, stencil
// datapath and ping-pong frame store. Depends on idd_pkg and idd_frame_ram.
`timescale 1ns / 1ps

// A frame store of grey pixels (kept as unsigned 8.FRACTION_BITS fixed point)
// is loaded by write beats, smoothed in place by a run beat, and read back by
// read beats; every accepted beat except opcode 3 returns one result beat.
// A write result is registered from the idle state; a read goes through an
// issue and a data state (registered memory read). A run first copies the
// whole newest frame into the other buffer, one word per cycle, then performs
// each pass as a setup state and, per interior pixel, the center, up, left,
// right, down, sum, multiply and write phases, since one memory read port
// feeds the five stencil taps one after another into a shared adder and
// multiplier. A run stops early once a pass changes no pixel. The input side
// is not ready while an item is at work; a finished result sits in the output
// register and the next beat is taken as soon as that slot is free or drains.
// Pixels must be written before they are read or diffused.
module isotropic_diffusion_denoise_core #(
    parameter int MAX_ROWS      = 256,
    parameter int MAX_COLUMNS   = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [9:2] row_index, [17:10] column_index, [25:18] pixel_in
    input  logic [31:0] s_tdata,
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] pixel_out, [9:8] completed_op
    output logic [15:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [idd_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    import idd_pkg::*;

    localparam int W     = PIXEL_INT_BITS + FRACTION_BITS; // stored pixel width
    localparam int STORE = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(STORE);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLUMNS + 1);
    localparam int SW    = W + 2;          // sum of four taps
    localparam int LW    = W + 3;          // signed laplacian
    localparam int PW    = LW + GAIN_SHIFT + 1; // signed product
    localparam logic [W-1:0] PIXEL_LIMIT = {W{1'b1}};

    // ---------------- input field unpack ----------------
    op_t        in_op;
    logic [7:0] in_row;
    logic [7:0] in_col;
    logic [7:0] in_pix;
    logic       in_inside;
    logic [AW-1:0] in_addr;

    assign in_op     = op_t'(s_tdata[1:0]);
    assign in_row    = s_tdata[9:2];
    assign in_col    = s_tdata[17:10];
    assign in_pix    = s_tdata[25:18];
    assign in_inside = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLUMNS);
    assign in_addr   = AW'(AW'(in_row) * AW'(MAX_COLUMNS) + AW'(in_col));

    // ---------------- registers ----------------
    state_t state_reg, state_next;
    logic [SIZE_WIDTH-1:0] rows_reg, rows_next;
    logic [SIZE_WIDTH-1:0] cols_reg, cols_next;
    logic [GAIN_WIDTH-1:0] gain_reg, gain_next;
    logic [PASS_WIDTH-1:0] passes_reg, passes_next;
    logic [PASS_WIDTH-1:0] left_reg, left_next;   // passes still to run
    logic sel_reg, sel_next;                       // 1: buffer b is newest

    logic m_valid_reg, m_valid_next;
    logic [7:0] m_pix_reg, m_pix_next;
    logic [1:0] m_op_reg, m_op_next;

    logic [AW-1:0] item_addr_reg, item_addr_next;
    logic item_inside_reg, item_inside_next;

    logic [AW-1:0] copy_addr_reg, copy_addr_next;
    logic [AW-1:0] copy_wa_reg, copy_wa_next;
    logic copy_wv_reg, copy_wv_next;

    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    phase_t ph_reg, ph_next;
    logic changed_reg, changed_next;

    logic [W-1:0]  p_reg, p_next;     // center tap
    logic [SW-1:0] sum_reg, sum_next; // neighbor sum
    logic signed [PW-1:0] prod_reg, prod_next;

    // ---------------- frame store ----------------
    logic          ram_we;
    logic          ram_wsel;  // 0: write newest buffer, 1: write the other
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  rdata_a, rdata_b, rdata;
    logic          we_a, we_b;

    assign we_a = ram_we && ((sel_reg ^ ram_wsel) == 1'b0);
    assign we_b = ram_we && ((sel_reg ^ ram_wsel) == 1'b1);

    idd_frame_ram #(.DEPTH(STORE), .WIDTH(W)) u_buf_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_a)
    );

    idd_frame_ram #(.DEPTH(STORE), .WIDTH(W)) u_buf_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_b)
    );

    // all reads come from the newest frame; sel only flips at pass end
    assign rdata = sel_reg ? rdata_b : rdata_a;

    // ---------------- sweep geometry ----------------
    logic [RCW-1:0] rows_eff, last_r;
    logic [CCW-1:0] cols_eff, last_c;
    logic [AW-1:0]  at;
    logic           at_last_c, at_last_r;

    assign rows_eff = (32'(rows_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_reg);
    assign cols_eff = (32'(cols_reg) > MAX_COLUMNS) ? CCW'(MAX_COLUMNS) : CCW'(cols_reg);
    assign last_r   = rows_eff - RCW'(2);
    assign last_c   = cols_eff - CCW'(2);
    assign at       = AW'(AW'(r_reg) * AW'(MAX_COLUMNS) + AW'(c_reg));
    assign at_last_c = (CCW'(c_reg) == last_c);
    assign at_last_r = (RCW'(r_reg) == last_r);

    // ---------------- stencil arithmetic ----------------
    logic signed [LW-1:0] lap;
    logic signed [PW-1:0] delta;
    logic signed [PW-1:0] sum_v;
    logic [W-1:0]         new_pix;

    assign lap = $signed(LW'(sum_reg)) - $signed(LW'(p_reg) << 2);

    always_comb begin
        // divide by 2^16, rounding toward zero
        if (prod_reg[PW-1]) begin
            delta = (prod_reg + PW'((1 << GAIN_SHIFT) - 1)) >>> GAIN_SHIFT;
        end else begin
            delta = prod_reg >>> GAIN_SHIFT;
        end
        sum_v = $signed(PW'(p_reg)) + delta;
        if (sum_v < 0) begin
            new_pix = '0;
        end else if (sum_v > $signed(PW'(PIXEL_LIMIT))) begin
            new_pix = PIXEL_LIMIT;
        end else begin
            new_pix = W'(sum_v);
        end
    end

    // ---------------- handshakes ----------------
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, m_op_reg, m_pix_reg};

    // ---------------- sequencer ----------------
    always_comb begin
        state_next       = state_reg;
        rows_next        = rows_reg;
        cols_next        = cols_reg;
        gain_next        = gain_reg;
        passes_next      = passes_reg;
        left_next        = left_reg;
        sel_next         = sel_reg;
        m_valid_next     = m_valid_reg;
        m_pix_next       = m_pix_reg;
        m_op_next        = m_op_reg;
        item_addr_next   = item_addr_reg;
        item_inside_next = item_inside_reg;
        copy_addr_next   = copy_addr_reg;
        copy_wa_next     = copy_wa_reg;
        copy_wv_next     = copy_wv_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        ph_next          = ph_reg;
        changed_next     = changed_reg;
        p_next           = p_reg;
        sum_next         = sum_reg;
        prod_next        = prod_reg;
        ram_we           = 1'b0;
        ram_wsel         = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = item_addr_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS:    rows_next   = cfg_data[SIZE_WIDTH-1:0];
                CFG_COLUMNS: cols_next   = cfg_data[SIZE_WIDTH-1:0];
                CFG_GAIN:    gain_next   = cfg_data[GAIN_WIDTH-1:0];
                CFG_PASSES:  passes_next = cfg_data[PASS_WIDTH-1:0];
                default:     ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    unique case (in_op)
                        OP_WRITE: begin
                            ram_we       = in_inside;
                            ram_waddr    = in_addr;
                            ram_wdata    = W'(in_pix) << FRACTION_BITS;
                            m_valid_next = 1'b1;
                            m_pix_next   = '0;
                            m_op_next    = OP_WRITE;
                        end
                        OP_RUN: begin
                            left_next      = passes_reg;
                            copy_addr_next = '0;
                            copy_wv_next   = 1'b0;
                            state_next     = ST_COPY;
                        end
                        OP_READ: begin
                            item_addr_next   = in_addr;
                            item_inside_next = in_inside;
                            state_next       = ST_READ_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ_ISSUE: begin
                ram_raddr  = item_addr_reg;
                state_next = ST_READ_DATA;
            end
            ST_READ_DATA: begin
                m_valid_next = 1'b1;
                m_pix_next   = item_inside_reg ? 8'(rdata >> FRACTION_BITS) : 8'd0;
                m_op_next    = OP_READ;
                state_next   = ST_IDLE;
            end
            ST_COPY: begin
                // read one word a cycle, write it in the cycle after
                ram_raddr    = copy_addr_reg;
                ram_we       = copy_wv_reg;
                ram_wsel     = 1'b1;
                ram_waddr    = copy_wa_reg;
                ram_wdata    = rdata;
                copy_wv_next = 1'b1;
                copy_wa_next = copy_addr_reg;
                if (copy_addr_reg == AW'(STORE - 1)) begin
                    state_next = ST_COPY_DRAIN;
                end else begin
                    copy_addr_next = copy_addr_reg + AW'(1);
                end
            end
            ST_COPY_DRAIN: begin
                ram_we       = 1'b1;
                ram_wsel     = 1'b1;
                ram_waddr    = copy_wa_reg;
                ram_wdata    = rdata;
                copy_wv_next = 1'b0;
                state_next   = ST_PASS_INIT;
            end
            ST_PASS_INIT: begin
                if (left_reg == '0 || 32'(rows_eff) < MIN_SIZE
                        || 32'(cols_eff) < MIN_SIZE) begin
                    state_next = ST_DONE;
                end else begin
                    r_next       = RW'(1);
                    c_next       = CW'(1);
                    ph_next      = PH_CENTER;
                    changed_next = 1'b0;
                    state_next   = ST_PIXEL;
                end
            end
            ST_PIXEL: begin
                ph_next = phase_t'(ph_reg + 3'd1);
                unique case (ph_reg)
                    PH_CENTER: ram_raddr = at;
                    PH_UP: begin
                        ram_raddr = at - AW'(MAX_COLUMNS);
                        p_next    = rdata;
                    end
                    PH_LEFT: begin
                        ram_raddr = at - AW'(1);
                        sum_next  = SW'(rdata);
                    end
                    PH_RIGHT: begin
                        ram_raddr = at + AW'(1);
                        sum_next  = sum_reg + SW'(rdata);
                    end
                    PH_DOWN: begin
                        ram_raddr = at + AW'(MAX_COLUMNS);
                        sum_next  = sum_reg + SW'(rdata);
                    end
                    PH_SUM: sum_next = sum_reg + SW'(rdata);
                    PH_MUL: begin
                        prod_next = PW'(lap) * $signed(PW'({1'b0, gain_reg}));
                    end
                    PH_WRITE: begin
                        ram_we    = 1'b1;
                        ram_wsel  = 1'b1;
                        ram_waddr = at;
                        ram_wdata = new_pix;
                        if (at_last_c) begin
                            c_next = CW'(1);
                            if (at_last_r) begin
                                // pass finished: the written buffer is newest
                                sel_next  = ~sel_reg;
                                left_next = left_reg - PASS_WIDTH'(1);
                                if (changed_reg || (new_pix != p_reg)) begin
                                    state_next = ST_PASS_INIT;
                                end else begin
                                    // buffers now agree; the remaining passes
                                    // would only swap them, so keep their parity
                                    sel_next   = ~sel_reg ^ left_next[0];
                                    state_next = ST_DONE;
                                end
                            end else begin
                                r_next = r_reg + RW'(1);
                            end
                        end else begin
                            c_next = c_reg + CW'(1);
                        end
                        changed_next = changed_reg || (new_pix != p_reg);
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                m_pix_next   = '0;
                m_op_next    = OP_RUN;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rows_reg    <= ROWS_RESET;
            cols_reg    <= COLUMNS_RESET;
            gain_reg    <= GAIN_RESET;
            passes_reg  <= PASSES_RESET;
            left_reg    <= '0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            copy_wv_reg <= 1'b0;
            ph_reg      <= PH_CENTER;
        end else begin
            state_reg   <= state_next;
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            gain_reg    <= gain_next;
            passes_reg  <= passes_next;
            left_reg    <= left_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            copy_wv_reg <= copy_wv_next;
            ph_reg      <= ph_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        m_pix_reg       <= m_pix_next;
        m_op_reg        <= m_op_next;
        item_addr_reg   <= item_addr_next;
        item_inside_reg <= item_inside_next;
        copy_addr_reg   <= copy_addr_next;
        copy_wa_reg     <= copy_wa_next;
        r_reg           <= r_next;
        c_reg           <= c_next;
        changed_reg     <= changed_next;
        p_reg           <= p_next;
        sum_reg         <= sum_next;
        prod_reg        <= prod_next;
    end

endmodule

@@ tb/sv/isotropic_diffusion_denoise_core_tb.sv @@
// Self-checking testbench for isotropic_diffusion_denoise_core: loads small
// frames, runs diffusion passes and reads pixels back against a built-in model.
// Depends on idd_pkg and the core RTL only.
`timescale 1ns / 1ps

module isotropic_diffusion_denoise_core_tb;
    import idd_pkg::*;

    localparam int STORE_COLS   = 256;
    localparam int STORE_WORDS  = 65536;
    localparam int FRAC         = 8;
    localparam int IDLE_LIMIT   = 400000;
    localparam int SETTLE       = 20;
    localparam logic [1:0] OP_UNUSED = 2'd3;   // dropped by the block, no result

    typedef struct packed {
        logic [7:0] pixel;
        logic [1:0] op;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    always #10 aclk = ~aclk;

    isotropic_diffusion_denoise_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---- model state: ping-pong frame store in 8.8 fixed point ----
    logic [15:0] frame_store [0:1][0:STORE_WORDS-1];
    bit          newest_sel;
    logic [8:0]  rows_reg;
    logic [8:0]  cols_reg;
    logic [14:0] gain_reg;
    logic [15:0] passes_reg;
    bit          pixel_written [0:STORE_WORDS-1];
    int          written_addrs [$];

    result_t     pending_results [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          recv_hold = 0;

    // apply the configured number of smoothing passes, stopping once stable
    task automatic diffuse_frame();
        int rows, cols, at;
        longint p, lap, delta, v;
        bit changed;
        rows = (rows_reg > 256) ? 256 : rows_reg;
        cols = (cols_reg > 256) ? 256 : cols_reg;
        for (int i = 0; i < STORE_WORDS; i++)
            frame_store[~newest_sel][i] = frame_store[newest_sel][i];
        for (int k = 0; k < passes_reg; k++) begin
            changed = 1'b0;
            for (int r = 1; r + 1 < rows; r++) begin
                for (int c = 1; c + 1 < cols; c++) begin
                    at = r * STORE_COLS + c;
                    p = frame_store[newest_sel][at];
                    lap = longint'(frame_store[newest_sel][at - STORE_COLS])
                        + frame_store[newest_sel][at - 1]
                        + frame_store[newest_sel][at + 1]
                        + frame_store[newest_sel][at + STORE_COLS] - 4 * p;
                    delta = (longint'(gain_reg) * lap) / 65536;
                    v = p + delta;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    if (v != p) changed = 1'b1;
                    frame_store[~newest_sel][at] = v[15:0];
                end
            end
            newest_sel ^= 1'b1;
            if (!changed) begin
                // both buffers agree; remaining passes only flip the parity
                newest_sel ^= 1'((passes_reg - 1 - k) & 1);
                break;
            end
        end
    endtask

    // expected result of one accepted beat
    task automatic predict_beat(logic [1:0] op, logic [7:0] row, logic [7:0] col,
                                logic [7:0] pix);
        int at;
        result_t res;
        at = row * STORE_COLS + col;
        res.pixel = '0;
        res.op = op;
        if (op == OP_UNUSED) return;
        if (op == OP_WRITE) begin
            frame_store[newest_sel][at] = {pix, 8'h00};
            if (!pixel_written[at]) begin
                pixel_written[at] = 1'b1;
                written_addrs.push_back(at);
            end
        end else if (op == OP_RUN) begin
            diffuse_frame();
        end else begin
            res.pixel = 8'(frame_store[newest_sel][at] >> FRAC);
        end
        pending_results.push_back(res);
    endtask

    // one input beat, with random sender gaps ahead of it
    task automatic send_beat(logic [1:0] op, logic [7:0] row, logic [7:0] col,
                             logic [7:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pix, col, row, op};
        do @(posedge aclk); while (!s_tready);
        predict_beat(op, row, col, pix);
    endtask

    // valid stays high between back-to-back writes; the caller drops it
    task automatic write_cfg(cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ROWS:    rows_reg   = value[8:0];
            CFG_COLUMNS: cols_reg   = value[8:0];
            CFG_GAIN:    gain_reg   = value[14:0];
            default:     passes_reg = value;
        endcase
    endtask

    // wait for every expected result, then let a dropped beat settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_beats(int count);
        int pick, at;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40 || written_addrs.size() == 0) begin
                send_beat(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 88) begin
                at = written_addrs[$urandom_range(written_addrs.size() - 1)];
                send_beat(OP_READ, 8'(at / STORE_COLS), 8'(at % STORE_COLS),
                          8'($urandom));
            end else begin
                send_beat(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // configure, load the whole image in use, smooth it and read it back
    task automatic frame_trial(logic [15:0] rows, logic [15:0] cols, logic [15:0] gain,
                               logic [15:0] passes, int before_run, int after_run);
        int rr, cc;
        drain();
        write_cfg(CFG_ROWS, rows);
        write_cfg(CFG_COLUMNS, cols);
        write_cfg(CFG_GAIN, gain);
        write_cfg(CFG_PASSES, passes);
        cfg_valid <= 1'b0;
        rr = (rows_reg > 256) ? 256 : rows_reg;
        cc = (cols_reg > 256) ? 256 : cols_reg;
        for (int r = 0; r < rr; r++)
            for (int c = 0; c < cc; c++)
                send_beat(OP_WRITE, 8'(r), 8'(c), 8'($urandom));
        random_beats(before_run);
        drain();                               // sender waits for the block to empty
        send_beat(OP_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
        random_beats(after_run);
    endtask

    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_beat(OP_WRITE, 8'd0, 8'd0, 8'd0);
        send_beat(OP_WRITE, 8'd255, 8'd255, 8'd255);
        send_beat(OP_READ, 8'd0, 8'd0, 8'd0);
        send_beat(OP_READ, 8'd255, 8'd255, 8'hff);
        send_beat(OP_UNUSED, 8'hff, 8'hff, 8'hff);
        send_beat(OP_READ, 8'd255, 8'd255, 8'd0);
        // 4x5 image, strongest stable gain, three passes
        frame_trial(16'd4, 16'd5, 16'd16384, 16'd3, 0, 12);
    endtask

    task automatic test_extreme_settings();
        // minimum image, zero gain: first pass is stable, huge pass count stops early
        send_idle_pct = 61; recv_stall_pct = 0;
        frame_trial(16'd3, 16'd3, 16'd0, 16'hffff, 10, 15);
        // rows above the store saturate; overshooting gain saturates pixels
        send_idle_pct = 0; recv_stall_pct = 61;
        frame_trial(16'h01ff, 16'd3, 16'h7fff, 16'd2, 20, 40);
        // no interior, zero passes keep the frame as loaded
        send_idle_pct = 26; recv_stall_pct = 26;
        frame_trial(16'd2, 16'd9, 16'd1000, 16'd0, 20, 40);
        // empty image, columns above the store saturate
        frame_trial(16'd0, 16'h01ff, 16'd5000, 16'd1, 10, 30);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        recv_hold = 400;                        // block fills and stalls its input
        random_beats(60);
        drain();
    endtask

    task automatic test_random_frames();
        for (int t = 0; t < 3; t++) begin
            send_idle_pct  = (t == 0) ? 61 : (t == 1) ? 0 : 26;
            recv_stall_pct = (t == 0) ? 0 : (t == 1) ? 61 : 26;
            frame_trial(16'($urandom_range(3, 8)), 16'($urandom_range(3, 8)),
                        ($urandom_range(3) == 0) ? 16'($urandom_range(32767))
                                                 : 16'($urandom_range(16384)),
                        16'($urandom_range(1, 4)), 30, 40);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.pixel || m_tdata[9:8] !== want.op) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel exp %0d got %0d, op exp %0d got %0d",
                                 want.pixel, m_tdata[7:0], want.op, m_tdata[9:8]);
                end
            end
        end
    end

    // receiver: long hold-offs on request, otherwise random stalls
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_WORDS; i++) begin
            frame_store[0][i] = '0;
            frame_store[1][i] = '0;
            pixel_written[i] = 1'b0;
        end
        newest_sel = 1'b0;
        rows_reg = ROWS_RESET; cols_reg = COLUMNS_RESET;
        gain_reg = GAIN_RESET; passes_reg = PASSES_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extreme_settings();
        test_backpressure();
        test_random_frames();
        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
